@@ rtl/lsf_pkg.sv @@
// shared types, constants and helpers for the landmark similarity fit
package lsf_pkg;

  // input word: one landmark pair
  typedef struct packed {
    logic signed [31:0] moving_x;
    logic signed [31:0] moving_y;
    logic signed [31:0] fixed_x;
    logic signed [31:0] fixed_y;
    logic               fixed_valid;
    logic               last_pair;
  } in_t;

  // output word: one fit result
  typedef struct packed {
    logic        [1:0]  status;
    logic signed [47:0] fwd_a;
    logic signed [47:0] fwd_b;
    logic signed [47:0] fwd_tx;
    logic signed [47:0] fwd_ty;
    logic        [47:0] rms_error;
    logic signed [47:0] inv_a;
    logic signed [47:0] inv_b;
    logic signed [47:0] inv_tx;
    logic signed [47:0] inv_ty;
  } out_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FEW   = 2'd1,
    ST_DEGEN = 2'd2,
    ST_OVF   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    DIV_RND   = 2'd0,
    DIV_TRUNC = 2'd1,
    DIV_SQRT  = 2'd2
  } div_mode_e;

  // multiplier request
  typedef struct packed {
    logic               start;
    logic signed [63:0] op_a;
    logic signed [63:0] op_b;
  } mul_req_t;

  // divider / square root request
  typedef struct packed {
    logic               start;
    div_mode_e          mode;
    logic signed [127:0] num;
    logic        [127:0] den;
  } div_req_t;

  localparam int unsigned MIN_PAIRS  = 2;
  localparam int unsigned MUL_DIGIT  = 16;
  localparam int unsigned MUL_STEPS  = 4;
  localparam int unsigned DIV_STEPS  = 128;
  localparam int unsigned SQRT_STEPS = 64;

  localparam logic signed [47:0]  SAT_HI  = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0]  SAT_LO  = {1'b1, {47{1'b0}}};
  localparam logic        [47:0]  MASK48  = {48{1'b1}};
  localparam logic signed [63:0]  RES_LIM = 64'sh0100_0000_0000_0000;

  // clamp a wide signed value into 48 bits
  function automatic logic signed [47:0] sat48(input logic signed [127:0] v);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi = 128'(SAT_HI);
    lo = 128'(SAT_LO);
    if (v > hi) return SAT_HI;
    if (v < lo) return SAT_LO;
    return v[47:0];
  endfunction

endpackage

@@ rtl/lsf_mul.sv @@
// shared signed 64x64 multiplier, one 16-bit digit per cycle
module lsf_mul import lsf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mul_req_t            req_i,
  output logic                done_o,
  output logic signed [127:0] prod_o
);

  typedef enum logic [2:0] {
    MP_IDLE = 3'b001,
    MP_RUN  = 3'b010,
    MP_FIN  = 3'b100
  } mphase_e;

  localparam int unsigned CNT_W = $clog2(MUL_STEPS);

  mphase_e             phase_q, phase_d;
  logic [63:0]         mag_a_q, mag_a_d;
  logic [63:0]         mag_b_q, mag_b_d;
  logic                neg_q, neg_d;
  logic [127:0]        acc_q, acc_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                done_q, done_d;
  logic signed [127:0] prod_q, prod_d;
  logic [79:0]         pp;

  // one partial product of the magnitude by the top digit
  assign pp = 80'(mag_a_q) * 80'(mag_b_q[63:64-MUL_DIGIT]);

  always_comb begin
    phase_d = phase_q;
    mag_a_d = mag_a_q;
    mag_b_d = mag_b_q;
    neg_d   = neg_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    prod_d  = prod_q;
    unique case (phase_q)
      MP_IDLE: begin
        if (req_i.start) begin
          mag_a_d = req_i.op_a[63] ? -req_i.op_a : req_i.op_a;
          mag_b_d = req_i.op_b[63] ? -req_i.op_b : req_i.op_b;
          neg_d   = req_i.op_a[63] ^ req_i.op_b[63];
          acc_d   = '0;
          cnt_d   = '0;
          phase_d = MP_RUN;
        end
      end
      MP_RUN: begin
        acc_d   = {acc_q[127-MUL_DIGIT:0], {MUL_DIGIT{1'b0}}} + {48'b0, pp};
        mag_b_d = mag_b_q << MUL_DIGIT;
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(MUL_STEPS - 1)) phase_d = MP_FIN;
      end
      MP_FIN: begin
        prod_d  = neg_q ? -acc_q : acc_q;
        done_d  = 1'b1;
        phase_d = MP_IDLE;
      end
      default: phase_d = MP_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= MP_IDLE;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    mag_a_q <= mag_a_d;
    mag_b_q <= mag_b_d;
    neg_q   <= neg_d;
    acc_q   <= acc_d;
    cnt_q   <= cnt_d;
    prod_q  <= prod_d;
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

@@ rtl/lsf_div.sv @@
// shared radix-2 divider and square root, one quotient or root bit per cycle
module lsf_div import lsf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  div_req_t            req_i,
  output logic                done_o,
  output logic signed [127:0] quo_o
);

  typedef enum logic [3:0] {
    DP_IDLE = 4'b0001,
    DP_PREP = 4'b0010,
    DP_RUN  = 4'b0100,
    DP_FIN  = 4'b1000
  } dphase_e;

  localparam int unsigned CNT_W = $clog2(DIV_STEPS);

  dphase_e             phase_q, phase_d;
  div_mode_e           mode_q, mode_d;
  logic                neg_q, neg_d;
  logic [127:0]        num_q, num_d;
  logic [127:0]        den_q, den_d;
  logic [129:0]        rem_q, rem_d;
  logic [127:0]        quo_q, quo_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                done_q, done_d;
  logic signed [127:0] res_q, res_d;

  logic                is_sqrt;
  logic                req_neg;
  logic [129:0]        rem_sh;
  logic [129:0]        trial;
  logic [129:0]        diff;
  logic                ge;
  logic                last;

  // shared shift, compare and subtract
  assign is_sqrt = (mode_q == DIV_SQRT);
  assign rem_sh  = is_sqrt ? {rem_q[127:0], num_q[127:126]} : {rem_q[128:0], num_q[127]};
  assign trial   = is_sqrt ? {quo_q, 2'b01} : {2'b00, den_q};
  assign diff    = rem_sh - trial;
  assign ge      = (rem_sh >= trial);
  assign last    = is_sqrt ? (cnt_q == CNT_W'(SQRT_STEPS - 1))
                           : (cnt_q == CNT_W'(DIV_STEPS - 1));
  assign req_neg = (req_i.mode == DIV_RND) && req_i.num[127];

  always_comb begin
    phase_d = phase_q;
    mode_d  = mode_q;
    neg_d   = neg_q;
    num_d   = num_q;
    den_d   = den_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    res_d   = res_q;
    unique case (phase_q)
      DP_IDLE: begin
        if (req_i.start) begin
          mode_d  = req_i.mode;
          neg_d   = req_neg;
          num_d   = req_neg ? -req_i.num : req_i.num;
          den_d   = req_i.den;
          phase_d = DP_PREP;
        end
      end
      DP_PREP: begin
        // round to nearest: add half the divisor to the magnitude
        if (mode_q == DIV_RND) num_d = num_q + {1'b0, den_q[127:1]};
        rem_d   = '0;
        quo_d   = '0;
        cnt_d   = '0;
        phase_d = DP_RUN;
      end
      DP_RUN: begin
        rem_d = ge ? diff : rem_sh;
        quo_d = {quo_q[126:0], ge};
        num_d = is_sqrt ? (num_q << 2) : (num_q << 1);
        cnt_d = cnt_q + 1'b1;
        if (last) phase_d = DP_FIN;
      end
      DP_FIN: begin
        res_d   = neg_q ? -quo_q : quo_q;
        done_d  = 1'b1;
        phase_d = DP_IDLE;
      end
      default: phase_d = DP_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= DP_IDLE;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    neg_q  <= neg_d;
    num_q  <= num_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    cnt_q  <= cnt_d;
    res_q  <= res_d;
  end

  assign done_o = done_q;
  assign quo_o  = res_q;

endmodule

@@ rtl/landmark_similarity_fit.sv @@
// least squares 2d similarity fit over a set of landmark pairs
//
// input channel (in_valid_i / in_ready_o / in_data_i): one landmark pair per word.
// pairs with fixed_valid low are dropped; usable pairs go into two point stores
// and into running coordinate sums, one word per cycle while the block is loading.
// a word with last_pair high closes the set; the block then drops in_ready_o and
// runs the fit on a sequencer around one shared multiplier (16-bit digits) and one
// shared radix-2 divider / square root unit; it makes two passes over the stores
// (16 products per pair), then the divisions, the root and the remaining products.
// a set that fails early (too few pairs, store overflow) skips to the output state.
// output channel (out_valid_o / out_ready_i / out_data_o): one result word per set,
// held in an output register; while it waits the block stays in its final state
// and loading resumes as soon as the result is registered.
// configuration channel (cfg_valid_i / cfg_ready_o / cfg_data_i): min_spread, always
// ready; write it only while the block is idle.
// reset clears the set, the result valid flag and min_spread; stores need no clear.
module landmark_similarity_fit import lsf_pkg::*; #(
  parameter int unsigned MAX_POINTS = 256,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [62:0] cfg_data_i
);

  localparam int unsigned IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned SUM_W = 32 + IDX_W;
  localparam logic [127:0] HALF = 128'(1) << (FRAC_BITS - 1);

  typedef enum logic [9:0] {
    S_LOAD  = 10'b00_0000_0001,
    S_CHECK = 10'b00_0000_0010,
    S_P1    = 10'b00_0000_0100,
    S_THR   = 10'b00_0000_1000,
    S_COEF  = 10'b00_0001_0000,
    S_TRANS = 10'b00_0010_0000,
    S_P2    = 10'b00_0100_0000,
    S_RMS   = 10'b00_1000_0000,
    S_INV   = 10'b01_0000_0000,
    S_OUT   = 10'b10_0000_0000
  } state_e;

  // round a residual to integer units and clamp it
  function automatic logic signed [63:0] res_round(input logic signed [127:0] x);
    logic [127:0]        m;
    logic [127:0]        q;
    logic signed [127:0] s;
    m = x[127] ? -x : x;
    q = (m + HALF) >> FRAC_BITS;
    s = x[127] ? -q : q;
    if (s > 128'(RES_LIM)) return RES_LIM;
    if (s < -128'(RES_LIM)) return -RES_LIM;
    return s[63:0];
  endfunction

  state_e              state_q, state_d;
  logic [3:0]          step_q, step_d;
  logic                busy_q, busy_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic signed [SUM_W-1:0] smx_q, smx_d, smy_q, smy_d, sfx_q, sfx_d, sfy_q, sfy_d;
  logic                ovf_q, ovf_d;
  logic [62:0]         min_spread_q;
  status_e             status_q, status_d;
  logic signed [127:0] dot_q, dot_d, crs_q, crs_d, spr_q, spr_d;
  logic signed [127:0] tmp_q, tmp_d, ssq_q, ssq_d;
  logic signed [63:0]  cu_q, cu_d, cv_q, cv_d, cp_q, cp_d, cq_q, cq_d, ex_q, ex_d;
  logic signed [47:0]  a_q, a_d, b_q, b_d, tx_q, tx_d, ty_q, ty_d;
  logic signed [47:0]  ia_q, ia_d, ib_q, ib_d, itx_q, itx_d, ity_q, ity_d;
  logic        [47:0]  rms_q, rms_d;
  out_t                out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic [63:0]         mov_mem [MAX_POINTS];
  logic [63:0]         fix_mem [MAX_POINTS];
  logic [63:0]         mov_rd_q, fix_rd_q;

  logic                in_fire;
  logic                wr_en;
  logic                issue;
  logic                fin;
  logic                loop_end;
  logic                mul_go, div_go;
  logic signed [63:0]  mul_a, mul_b;
  logic signed [127:0] div_num;
  logic [127:0]        div_den;
  div_mode_e           div_mode;
  mul_req_t            mul_req;
  div_req_t            div_req;
  logic                mul_done, div_done;
  logic signed [127:0] mul_prod, div_quo;

  logic signed [63:0]  n64;
  logic [127:0]        n128;
  logic signed [63:0]  mx, my, fx, fy;
  logic signed [127:0] sfx_w, sfy_w;

  assign in_ready_o  = (state_q == S_LOAD);
  assign in_fire     = in_valid_i && in_ready_o;
  assign wr_en       = in_fire && in_data_i.fixed_valid && (cnt_q < CNT_W'(MAX_POINTS));
  assign cfg_ready_o = 1'b1;

  assign n64   = 64'(cnt_q);
  assign n128  = 128'(cnt_q);
  assign mx    = 64'($signed(mov_rd_q[63:32]));
  assign my    = 64'($signed(mov_rd_q[31:0]));
  assign fx    = 64'($signed(fix_rd_q[63:32]));
  assign fy    = 64'($signed(fix_rd_q[31:0]));
  assign sfx_w = 128'(sfx_q);
  assign sfy_w = 128'(sfy_q);

  assign issue    = !busy_q;
  assign fin      = busy_q && (mul_done || div_done);
  assign loop_end = (CNT_W'(idx_q) + 1'b1 == cnt_q);

  // point stores: one write port for loading, one registered read port for the passes
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mov_mem[cnt_q[IDX_W-1:0]] <= {in_data_i.moving_x, in_data_i.moving_y};
      fix_mem[cnt_q[IDX_W-1:0]] <= {in_data_i.fixed_x, in_data_i.fixed_y};
    end
    mov_rd_q <= mov_mem[idx_q];
    fix_rd_q <= fix_mem[idx_q];
  end

  // shared arithmetic units
  assign mul_req = '{start: mul_go, op_a: mul_a, op_b: mul_b};
  assign div_req = '{start: div_go, mode: div_mode, num: div_num, den: div_den};

  lsf_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  lsf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    smx_d       = smx_q;
    smy_d       = smy_q;
    sfx_d       = sfx_q;
    sfy_d       = sfy_q;
    ovf_d       = ovf_q;
    status_d    = status_q;
    dot_d       = dot_q;
    crs_d       = crs_q;
    spr_d       = spr_q;
    tmp_d       = tmp_q;
    ssq_d       = ssq_q;
    cu_d        = cu_q;
    cv_d        = cv_q;
    cp_d        = cp_q;
    cq_d        = cq_q;
    ex_d        = ex_q;
    a_d         = a_q;
    b_d         = b_q;
    tx_d        = tx_q;
    ty_d        = ty_q;
    ia_d        = ia_q;
    ib_d        = ib_q;
    itx_d       = itx_q;
    ity_d       = ity_q;
    rms_d       = rms_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mul_go      = 1'b0;
    div_go      = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    div_num     = '0;
    div_den     = '0;
    div_mode    = DIV_RND;

    unique case (state_q)
      S_LOAD: begin
        if (in_fire) begin
          if (in_data_i.fixed_valid) begin
            if (wr_en) begin
              cnt_d = cnt_q + 1'b1;
              smx_d = smx_q + SUM_W'($signed(in_data_i.moving_x));
              smy_d = smy_q + SUM_W'($signed(in_data_i.moving_y));
              sfx_d = sfx_q + SUM_W'($signed(in_data_i.fixed_x));
              sfy_d = sfy_q + SUM_W'($signed(in_data_i.fixed_y));
            end else begin
              ovf_d = 1'b1;
            end
          end
          if (in_data_i.last_pair) state_d = S_CHECK;
        end
      end

      S_CHECK: begin
        ia_d   = '0;
        ib_d   = '0;
        itx_d  = '0;
        ity_d  = '0;
        rms_d  = '0;
        dot_d  = '0;
        crs_d  = '0;
        spr_d  = '0;
        ssq_d  = '0;
        idx_d  = '0;
        step_d = '0;
        if (cnt_q < CNT_W'(MIN_PAIRS)) begin
          status_d = ST_FEW;
          state_d  = S_OUT;
        end else if (ovf_q) begin
          status_d = ST_OVF;
          state_d  = S_OUT;
        end else begin
          status_d = ST_OK;
          state_d  = S_P1;
        end
      end

      // first pass: centered sums scaled by n squared
      S_P1: begin
        unique case (step_q)
          4'd0: step_d = step_q + 1'b1;
          4'd1: begin
            mul_a = n64; mul_b = mx; mul_go = issue;
            if (fin) begin cu_d = mul_prod[63:0] - 64'(smx_q); step_d = step_q + 1'b1; end
          end
          4'd2: begin
            mul_a = n64; mul_b = my; mul_go = issue;
            if (fin) begin cv_d = mul_prod[63:0] - 64'(smy_q); step_d = step_q + 1'b1; end
          end
          4'd3: begin
            mul_a = n64; mul_b = fx; mul_go = issue;
            if (fin) begin cp_d = mul_prod[63:0] - 64'(sfx_q); step_d = step_q + 1'b1; end
          end
          4'd4: begin
            mul_a = n64; mul_b = fy; mul_go = issue;
            if (fin) begin cq_d = mul_prod[63:0] - 64'(sfy_q); step_d = step_q + 1'b1; end
          end
          4'd5: begin
            mul_a = cu_q; mul_b = cp_q; mul_go = issue;
            if (fin) begin dot_d = dot_q + mul_prod; step_d = step_q + 1'b1; end
          end
          4'd6: begin
            mul_a = cv_q; mul_b = cq_q; mul_go = issue;
            if (fin) begin dot_d = dot_q + mul_prod; step_d = step_q + 1'b1; end
          end
          4'd7: begin
            mul_a = cu_q; mul_b = cq_q; mul_go = issue;
            if (fin) begin crs_d = crs_q + mul_prod; step_d = step_q + 1'b1; end
          end
          4'd8: begin
            mul_a = cv_q; mul_b = cp_q; mul_go = issue;
            if (fin) begin crs_d = crs_q - mul_prod; step_d = step_q + 1'b1; end
          end
          4'd9: begin
            mul_a = cu_q; mul_b = cu_q; mul_go = issue;
            if (fin) begin spr_d = spr_q + mul_prod; step_d = step_q + 1'b1; end
          end
          4'd10: begin
            mul_a = cv_q; mul_b = cv_q; mul_go = issue;
            if (fin) begin
              spr_d  = spr_q + mul_prod;
              step_d = '0;
              if (loop_end) state_d = S_THR;
              else idx_d = idx_q + 1'b1;
            end
          end
          default: step_d = '0;
        endcase
      end

      // spread threshold: min_spread * n^2 * one
      S_THR: begin
        unique case (step_q)
          4'd0: begin
            mul_a = n64; mul_b = n64; mul_go = issue;
            if (fin) begin tmp_d = mul_prod; step_d = step_q + 1'b1; end
          end
          4'd1: begin
            mul_a = 64'(min_spread_q); mul_b = tmp_q[63:0] << FRAC_BITS; mul_go = issue;
            if (fin) begin tmp_d = mul_prod; step_d = step_q + 1'b1; end
          end
          4'd2: begin
            step_d = '0;
            if (spr_q <= tmp_q) begin
              status_d = ST_DEGEN;
              state_d  = S_OUT;
            end else begin
              state_d = S_COEF;
            end
          end
          default: step_d = '0;
        endcase
      end

      // a = dot / spread, b = cross / spread
      S_COEF: begin
        div_den = spr_q;
        unique case (step_q)
          4'd0: begin
            div_num = dot_q <<< FRAC_BITS; div_go = issue;
            if (fin) begin a_d = sat48(div_quo); step_d = step_q + 1'b1; end
          end
          4'd1: begin
            div_num = crs_q <<< FRAC_BITS; div_go = issue;
            if (fin) begin b_d = sat48(div_quo); step_d = '0; state_d = S_TRANS; end
          end
          default: step_d = '0;
        endcase
      end

      // translation from the means
      S_TRANS: begin
        div_den = n128 << FRAC_BITS;
        unique case (step_q)
          4'd0: begin
            mul_a = 64'(a_q); mul_b = 64'(smx_q); mul_go = issue;
            if (fin) begin tmp_d = (sfx_w <<< FRAC_BITS) - mul_prod; step_d = step_q + 1'b1; end
          end
          4'd1: begin
            mul_a = 64'(b_q); mul_b = 64'(smy_q); mul_go = issue;
            if (fin) begin tmp_d = tmp_q + mul_prod; step_d = step_q + 1'b1; end
          end
          4'd2: begin
            div_num = tmp_q; div_go = issue;
            if (fin) begin tx_d = sat48(div_quo); step_d = step_q + 1'b1; end
          end
          4'd3: begin
            mul_a = 64'(b_q); mul_b = 64'(smx_q); mul_go = issue;
            if (fin) begin tmp_d = (sfy_w <<< FRAC_BITS) - mul_prod; step_d = step_q + 1'b1; end
          end
          4'd4: begin
            mul_a = 64'(a_q); mul_b = 64'(smy_q); mul_go = issue;
            if (fin) begin tmp_d = tmp_q - mul_prod; step_d = step_q + 1'b1; end
          end
          4'd5: begin
            div_num = tmp_q; div_go = issue;
            if (fin) begin
              ty_d    = sat48(div_quo);
              step_d  = '0;
              idx_d   = '0;
              state_d = S_P2;
            end
          end
          default: step_d = '0;
        endcase
      end

      // second pass: squared residuals
      S_P2: begin
        unique case (step_q)
          4'd0: step_d = step_q + 1'b1;
          4'd1: begin
            mul_a = 64'(a_q); mul_b = mx; mul_go = issue;
            if (fin) begin
              tmp_d  = mul_prod + (128'(64'(tx_q) - fx) <<< FRAC_BITS);
              step_d = step_q + 1'b1;
            end
          end
          4'd2: begin
            mul_a = 64'(b_q); mul_b = my; mul_go = issue;
            if (fin) begin tmp_d = tmp_q - mul_prod; step_d = step_q + 1'b1; end
          end
          4'd3: begin
            ex_d   = res_round(tmp_q);
            step_d = step_q + 1'b1;
          end
          4'd4: begin
            mul_a = ex_q; mul_b = ex_q; mul_go = issue;
            if (fin) begin ssq_d = ssq_q + mul_prod; step_d = step_q + 1'b1; end
          end
          4'd5: begin
            mul_a = 64'(b_q); mul_b = mx; mul_go = issue;
            if (fin) begin
              tmp_d  = mul_prod + (128'(64'(ty_q) - fy) <<< FRAC_BITS);
              step_d = step_q + 1'b1;
            end
          end
          4'd6: begin
            mul_a = 64'(a_q); mul_b = my; mul_go = issue;
            if (fin) begin tmp_d = tmp_q + mul_prod; step_d = step_q + 1'b1; end
          end
          4'd7: begin
            ex_d   = res_round(tmp_q);
            step_d = step_q + 1'b1;
          end
          4'd8: begin
            mul_a = ex_q; mul_b = ex_q; mul_go = issue;
            if (fin) begin
              ssq_d  = ssq_q + mul_prod;
              step_d = '0;
              if (loop_end) state_d = S_RMS;
              else idx_d = idx_q + 1'b1;
            end
          end
          default: step_d = '0;
        endcase
      end

      // rms = floor(sqrt(floor(ssq / n)))
      S_RMS: begin
        unique case (step_q)
          4'd0: begin
            div_mode = DIV_TRUNC; div_num = ssq_q; div_den = n128; div_go = issue;
            if (fin) begin tmp_d = div_quo; step_d = step_q + 1'b1; end
          end
          4'd1: begin
            div_mode = DIV_SQRT; div_num = tmp_q; div_go = issue;
            if (fin) begin
              rms_d   = (|div_quo[127:48]) ? MASK48 : div_quo[47:0];
              step_d  = '0;
              state_d = S_INV;
            end
          end
          default: step_d = '0;
        endcase
      end

      // inverse transform, divisor a^2 + b^2 kept in the spread register
      S_INV: begin
        div_den = spr_q;
        unique case (step_q)
          4'd0: begin
            mul_a = 64'(a_q); mul_b = 64'(a_q); mul_go = issue;
            if (fin) begin spr_d = mul_prod; step_d = step_q + 1'b1; end
          end
          4'd1: begin
            mul_a = 64'(b_q); mul_b = 64'(b_q); mul_go = issue;
            if (fin) begin spr_d = spr_q + mul_prod; step_d = step_q + 1'b1; end
          end
          4'd2: begin
            if (spr_q == '0) begin
              step_d  = '0;
              state_d = S_OUT;
            end else begin
              step_d = step_q + 1'b1;
            end
          end
          4'd3: begin
            div_num = 128'(a_q) <<< (2 * FRAC_BITS); div_go = issue;
            if (fin) begin ia_d = sat48(div_quo); step_d = step_q + 1'b1; end
          end
          4'd4: begin
            div_num = -(128'(b_q) <<< (2 * FRAC_BITS)); div_go = issue;
            if (fin) begin ib_d = sat48(div_quo); step_d = step_q + 1'b1; end
          end
          4'd5: begin
            mul_a = 64'(a_q); mul_b = 64'(tx_q); mul_go = issue;
            if (fin) begin tmp_d = mul_prod; step_d = step_q + 1'b1; end
          end
          4'd6: begin
            mul_a = 64'(b_q); mul_b = 64'(ty_q); mul_go = issue;
            if (fin) begin tmp_d = tmp_q + mul_prod; step_d = step_q + 1'b1; end
          end
          4'd7: begin
            div_num = -(tmp_q <<< FRAC_BITS); div_go = issue;
            if (fin) begin itx_d = sat48(div_quo); step_d = step_q + 1'b1; end
          end
          4'd8: begin
            mul_a = 64'(b_q); mul_b = 64'(tx_q); mul_go = issue;
            if (fin) begin tmp_d = mul_prod; step_d = step_q + 1'b1; end
          end
          4'd9: begin
            mul_a = 64'(a_q); mul_b = 64'(ty_q); mul_go = issue;
            if (fin) begin tmp_d = tmp_q - mul_prod; step_d = step_q + 1'b1; end
          end
          4'd10: begin
            div_num = tmp_q <<< FRAC_BITS; div_go = issue;
            if (fin) begin
              ity_d   = sat48(div_quo);
              step_d  = '0;
              state_d = S_OUT;
            end
          end
          default: step_d = '0;
        endcase
      end

      // hand the result to the output register and clear the set
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d           = '0;
          out_d.status    = status_q;
          if (status_q == ST_OK) begin
            out_d.fwd_a     = a_q;
            out_d.fwd_b     = b_q;
            out_d.fwd_tx    = tx_q;
            out_d.fwd_ty    = ty_q;
            out_d.rms_error = rms_q;
            out_d.inv_a     = ia_q;
            out_d.inv_b     = ib_q;
            out_d.inv_tx    = itx_q;
            out_d.inv_ty    = ity_q;
          end
          out_valid_d = 1'b1;
          cnt_d       = '0;
          smx_d       = '0;
          smy_d       = '0;
          sfx_d       = '0;
          sfy_d       = '0;
          ovf_d       = 1'b0;
          state_d     = S_LOAD;
        end
      end

      default: state_d = S_LOAD;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_LOAD;
      step_q       <= '0;
      busy_q       <= 1'b0;
      cnt_q        <= '0;
      smx_q        <= '0;
      smy_q        <= '0;
      sfx_q        <= '0;
      sfy_q        <= '0;
      ovf_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      min_spread_q <= '0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      busy_q      <= busy_q ? !(mul_done || div_done) : (mul_go || div_go);
      cnt_q       <= cnt_d;
      smx_q       <= smx_d;
      smy_q       <= smy_d;
      sfx_q       <= sfx_d;
      sfy_q       <= sfy_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) min_spread_q <= cfg_data_i;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    status_q <= status_d;
    dot_q    <= dot_d;
    crs_q    <= crs_d;
    spr_q    <= spr_d;
    tmp_q    <= tmp_d;
    ssq_q    <= ssq_d;
    cu_q     <= cu_d;
    cv_q     <= cv_d;
    cp_q     <= cp_d;
    cq_q     <= cq_d;
    ex_q     <= ex_d;
    a_q      <= a_d;
    b_q      <= b_d;
    tx_q     <= tx_d;
    ty_q     <= ty_d;
    ia_q     <= ia_d;
    ib_q     <= ib_d;
    itx_q    <= itx_d;
    ity_q    <= ity_d;
    rms_q    <= rms_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/lsf_chk.sv @@
// port-level checks for the landmark similarity fit, bound to the top level
module lsf_chk import lsf_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input in_t         in_data_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input out_t        out_data_o
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // closing a set stops loading
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.last_pair |=> !in_ready_o)
    else $error("input still ready after last pair");

  // a new result only appears at the end of a fit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared while loading");

  // a failed fit carries no coefficients
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_OK) |->
      (out_data_o.fwd_a == '0) && (out_data_o.fwd_b == '0) &&
      (out_data_o.fwd_tx == '0) && (out_data_o.fwd_ty == '0) &&
      (out_data_o.rms_error == '0) && (out_data_o.inv_a == '0) &&
      (out_data_o.inv_b == '0) && (out_data_o.inv_tx == '0) &&
      (out_data_o.inv_ty == '0))
    else $error("failed fit with nonzero fields");

endmodule

bind landmark_similarity_fit lsf_chk u_lsf_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
